@@ sv/hwg_pkg.sv @@
package hwg_pkg;

	// Configuration register widths and reset values
	localparam int WL_W        = 17;
	localparam int STEP_W      = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 1;

	localparam logic [WL_W-1:0]   WL_RESET   = 17'd64;
	localparam logic [STEP_W-1:0] STEP_RESET = 32'd68174084;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 1'd1;

	// Datapath widths of the sine series; terms are Q2.30
	localparam int ANGLE_W = 32;
	localparam int TERM_W  = 32;
	localparam int SUM_W   = 34;
	localparam int SINE_W  = 31;
	localparam int SQ_W    = 62;
	localparam int FRAC_W  = 30;

	localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0]        PI_Q30    = 32'd3373259426;
	localparam logic [SINE_W-1:0]  ONE_Q30   = 31'h4000_0000;

	// Sideband that travels with each coefficient down the pipeline
	typedef struct packed {
		logic force_one;
		logic last;
	} side_t;

endpackage

@@ sv/hwg_phase_seq.sv @@
module hwg_phase_seq import hwg_pkg::*; #(
	parameter int MAX_LENGTH  = 65536,
	parameter int PHASE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                restart,
	input  logic [WL_W-1:0]     window_length,
	input  logic [STEP_W-1:0]   phase_step,
	output logic [ANGLE_W-1:0]  angle,
	output side_t               side
);

	localparam int IW    = $clog2(MAX_LENGTH);
	localparam int ML_W  = $clog2(MAX_LENGTH + 1);
	localparam int LW    = (ML_W > WL_W) ? ML_W : WL_W;

	logic [IW-1:0]          index_q;
	logic [PHASE_WIDTH-1:0] phase_q;
	logic [IW-1:0]          cur_index;
	logic [PHASE_WIDTH-1:0] cur_phase;
	logic [PHASE_WIDTH-1:0] step_ext;
	logic [LW-1:0]          wl_ext;
	logic [LW-1:0]          len;
	logic                   is_last;

	// Clamp the length into one to MAX_LENGTH
	always_comb begin
		wl_ext = LW'(window_length);
		if (wl_ext == '0) begin
			len = LW'(1);
		end else if (wl_ext > LW'(MAX_LENGTH)) begin
			len = LW'(MAX_LENGTH);
		end else begin
			len = wl_ext;
		end
	end

	// Restart takes index and phase back to zero on this transaction
	assign cur_index = restart ? '0 : index_q;
	assign cur_phase = restart ? '0 : phase_q;
	assign is_last   = LW'(cur_index) >= (len - LW'(1));
	assign step_ext  = PHASE_WIDTH'(phase_step);

	assign side.last      = is_last;
	assign side.force_one = (len == LW'(1));

	// Take the top 32 bits of the phase as the angle, padding a narrower phase with zeros
	generate
		if (PHASE_WIDTH >= ANGLE_W) begin : g_wide
			assign angle = cur_phase[PHASE_WIDTH-1 -: ANGLE_W];
		end else begin : g_narrow
			assign angle = {cur_phase, (ANGLE_W - PHASE_WIDTH)'(0)};
		end
	endgenerate

	// Advance or wrap the sample counter and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			phase_q <= '0;
		end else if (accept) begin
			if (is_last) begin
				index_q <= '0;
				phase_q <= '0;
			end else begin
				index_q <= cur_index + IW'(1);
				phase_q <= cur_phase + step_ext;
			end
		end
	end

	a_one_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && side.force_one |-> side.last)
		else $error("length one coefficient not flagged last");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_last |=> index_q == '0 && phase_q == '0)
		else $error("counter did not wrap after last coefficient");

endmodule

@@ sv/hwg_series_step.sv @@
module hwg_series_step import hwg_pkg::*; #(
	parameter int STEP = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    vld_in,
	input  side_t                   side_in,
	input  logic [TERM_W-1:0]       term_in,
	input  logic signed [SUM_W-1:0] sum_in,
	input  logic [TERM_W-1:0]       x2_in,
	output logic                    vld_out,
	output side_t                   side_out,
	output logic [TERM_W-1:0]       term_out,
	output logic signed [SUM_W-1:0] sum_out,
	output logic [TERM_W-1:0]       x2_out
);

	// Exact floor division by a constant through a rounded-up reciprocal
	localparam int DIVISOR  = (2 * STEP) * (2 * STEP + 1);
	localparam int SHIFT    = TERM_W + $clog2(DIVISOR);
	localparam int RW       = TERM_W + 1;
	localparam logic [RW-1:0] RECIP =
		RW'(((65'd1 << SHIFT) + 65'(DIVISOR) - 65'd1) / 65'(DIVISOR));
	localparam bit SUBTRACT = ((STEP - 1) % 2) == 1;

	logic                    vld_s1;
	logic                    vld_s2;
	side_t                   side_s1;
	side_t                   side_s2;
	logic [TERM_W-1:0]       t_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic [TERM_W-1:0]       x2_s1;
	logic [TERM_W-1:0]       term_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic [TERM_W-1:0]       x2_s2;
	logic signed [SUM_W-1:0] term_ext;

	assign term_ext = $signed(SUM_W'(term_in));

	// Hold valid and sideband while the pipeline stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	// Multiply by x^2, fold the previous term into the sum, then divide
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			t_s1    <= TERM_W'((64'(term_in) * 64'(x2_in)) >> FRAC_W);
			sum_s1  <= SUBTRACT ? (sum_in - term_ext) : (sum_in + term_ext);
			x2_s1   <= x2_in;
			side_s2 <= side_s1;
			term_s2 <= TERM_W'((65'(t_s1) * 65'(RECIP)) >> SHIFT);
			sum_s2  <= sum_s1;
			x2_s2   <= x2_s1;
		end
	end

	assign vld_out  = vld_s2;
	assign side_out = side_s2;
	assign term_out = term_s2;
	assign sum_out  = sum_s2;
	assign x2_out   = x2_s2;

endmodule

@@ sv/hwg_sine_pipe.sv @@
module hwg_sine_pipe import hwg_pkg::*; #(
	parameter int COEF_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  vld_in,
	input  logic [ANGLE_W-1:0]    angle,
	input  side_t                 side_in,
	output logic                  vld_out,
	output logic [COEF_WIDTH-1:0] coefficient,
	output side_t                 side_out
);

	localparam int NSTEP = 5;
	localparam int SH    = 60 - (COEF_WIDTH - 1);
	localparam int RB_W  = SQ_W - SH;
	localparam logic [SQ_W-1:0]       HALF = SQ_W'(1) << (SH - 1);
	localparam logic [RB_W-1:0]       ONE_R = RB_W'(1) << (COEF_WIDTH - 1);
	localparam logic [COEF_WIDTH-1:0] ONE   = COEF_WIDTH'(1) << (COEF_WIDTH - 1);

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s15, vld_s16, vld_s17;
	side_t                   side_s1, side_s2, side_s3, side_s4, side_s15, side_s16, side_s17;
	logic [ANGLE_W-1:0]      angle_s1;
	logic [ANGLE_W-1:0]      u_s2;
	logic [TERM_W-1:0]       x_s3;
	logic [TERM_W-1:0]       x_s4;
	logic [TERM_W-1:0]       x2_s4;
	logic [SINE_W-1:0]       sine_s15;
	logic [SQ_W-1:0]         sq_s16;
	logic [COEF_WIDTH-1:0]   coef_s17;

	logic                    st_vld  [0:NSTEP];
	side_t                   st_side [0:NSTEP];
	logic [TERM_W-1:0]       st_term [0:NSTEP];
	logic signed [SUM_W-1:0] st_sum  [0:NSTEP];
	logic [TERM_W-1:0]       st_x2   [0:NSTEP];

	logic signed [SUM_W-1:0] fin_sum;
	logic [SINE_W-1:0]       fin_sine;
	logic [SQ_W-1:0]         rnd_sum;
	logic [RB_W-1:0]         rnd;
	logic [COEF_WIDTH-1:0]   coef_next;

	// Advance valid bits through the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s15 <= st_vld[NSTEP];
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
		end
	end

	// Fold the angle into a quarter turn, scale by pi, square it
	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s1 <= angle;
			side_s1  <= side_in;
			u_s2     <= (angle_s1 > HALF_TURN) ?
				ANGLE_W'(33'h1_0000_0000 - 33'(angle_s1)) : angle_s1;
			side_s2  <= side_s1;
			x_s3     <= TERM_W'((64'(u_s2) * 64'(PI_Q30)) >> 32);
			side_s3  <= side_s2;
			x_s4     <= x_s3;
			x2_s4    <= TERM_W'((64'(x_s3) * 64'(x_s3)) >> FRAC_W);
			side_s4  <= side_s3;
		end
	end

	// Odd Taylor series, one term per step
	assign st_vld[0]  = vld_s4;
	assign st_side[0] = side_s4;
	assign st_term[0] = x_s4;
	assign st_sum[0]  = '0;
	assign st_x2[0]   = x2_s4;

	generate
		for (genvar k = 1; k <= NSTEP; k++) begin : g_step
			hwg_series_step #(.STEP(k)) u_step (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.vld_in   (st_vld[k-1]),
				.side_in  (st_side[k-1]),
				.term_in  (st_term[k-1]),
				.sum_in   (st_sum[k-1]),
				.x2_in    (st_x2[k-1]),
				.vld_out  (st_vld[k]),
				.side_out (st_side[k]),
				.term_out (st_term[k]),
				.sum_out  (st_sum[k]),
				.x2_out   (st_x2[k])
			);
		end
	endgenerate

	// Subtract the last term and clamp the sine to [0, 1]
	always_comb begin
		fin_sum = st_sum[NSTEP] - $signed(SUM_W'(st_term[NSTEP]));
		if (fin_sum < 0) begin
			fin_sine = '0;
		end else if (fin_sum > $signed(SUM_W'(ONE_Q30))) begin
			fin_sine = ONE_Q30;
		end else begin
			fin_sine = SINE_W'(fin_sum);
		end
	end

	// Round the square to the output format and saturate at one, or give one for a length-one window
	always_comb begin
		rnd_sum = sq_s16 + HALF;
		rnd     = rnd_sum[SQ_W-1:SH];
		if (side_s16.force_one || rnd > ONE_R) begin
			coef_next = ONE;
		end else begin
			coef_next = COEF_WIDTH'(rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sine_s15 <= fin_sine;
			side_s15 <= st_side[NSTEP];
			sq_s16   <= SQ_W'(sine_s15) * SQ_W'(sine_s15);
			side_s16 <= side_s15;
			coef_s17 <= coef_next;
			side_s17 <= side_s16;
		end
	end

	assign vld_out     = vld_s17;
	assign coefficient = coef_s17;
	assign side_out    = side_s17;

	a_force_one: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s17 && side_s17.force_one |-> coef_s17 == ONE)
		else $error("length one window did not give one");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s17 |-> coef_s17 <= ONE)
		else $error("coefficient above one");

	a_square_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s16 |-> sq_s16 <= (SQ_W'(1) << 60))
		else $error("sine square above one");

endmodule

@@ sv/hann_window_generator_unit.sv @@
// Symmetric Hann window source. Each accepted transaction on the input
// channel yields one coefficient w[n] = sin^2(pi*n/(M-1)) in unsigned
// Q1.(COEF_WIDTH-1), with last set on index M-1, after which the index
// and phase wrap to zero; restart emits index zero on that transaction.
// Throughput is one coefficient per clock, but all stages, the output
// register too, hold together while a valid output is stalled. The
// stages are the fold and pi scaling, a six-term sine series
// (multiply by x^2 and exact reciprocal divide per later term), square
// and round. Write window_length (index 0) and phase_step (index 1,
// round(2^32/(M-1))) only while no coefficient is in flight.
module hann_window_generator_unit import hwg_pkg::*; #(
	parameter int MAX_LENGTH  = 65536,
	parameter int PHASE_WIDTH = 32,
	parameter int COEF_WIDTH  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COEF_WIDTH-1:0] coefficient,
	output logic                  last
);

	logic [WL_W-1:0]    window_length_q;
	logic [STEP_W-1:0]  phase_step_q;
	logic               adv;
	logic               accept;
	logic [ANGLE_W-1:0] angle;
	side_t              side;
	side_t              side_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WL_RESET;
			phase_step_q    <= STEP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[WL_W-1:0];
				CFG_PHASE_STEP:    phase_step_q    <= cfg_data[STEP_W-1:0];
				default:           ;
			endcase
		end
	end

	// Advance the whole pipeline unless a finished result is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	hwg_phase_seq #(
		.MAX_LENGTH  (MAX_LENGTH),
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.restart       (restart),
		.window_length (window_length_q),
		.phase_step    (phase_step_q),
		.angle         (angle),
		.side          (side)
	);

	hwg_sine_pipe #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.vld_in      (accept),
		.angle       (angle),
		.side_in     (side),
		.vld_out     (out_valid),
		.coefficient (coefficient),
		.side_out    (side_out)
	);

	assign last = side_out.last;

endmodule
